// ===== sv/fhd_pkg.sv =====
// ----------------------------------------------------------------------------
// fhd_pkg: shared definitions for the fire heat diffusion block
// Grid geometry, register indexes, generator and palette helpers.
// ----------------------------------------------------------------------------
package fhd_pkg;

  localparam int GRID_ROWS = 16;
  localparam int GRID_COLS = 16;
  localparam int CELLS     = GRID_ROWS * GRID_COLS;
  localparam int ROW_W     = $clog2(GRID_ROWS);
  localparam int COL_W     = $clog2(GRID_COLS);
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int CFG_IDX_W = 3;

  localparam logic [31:0] SEED_DEFAULT = 32'h9E37_79B9;
  // floor(n * 10923 / 2^16) == floor(n / 6) for n < 2048
  localparam logic [13:0] RECIP6 = 14'd10923;

  localparam logic [7:0] THR_RESET   = 8'd64;
  localparam logic [7:0] SPARK_RESET = 8'd160;
  localparam logic [7:0] COOL_RESET  = 8'd8;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PALETTE_MODE    = 3'd0,
    REG_SPAWN_THRESHOLD = 3'd1,
    REG_SPARK_MIN       = 3'd2,
    REG_COOLING         = 3'd3,
    REG_RNG_SEED        = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  function automatic logic [31:0] xs32(input logic [31:0] s);
    logic [31:0] x;
    x = s ^ (s << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    return ADDR_W'(ADDR_W'(r) * ADDR_W'(GRID_COLS)) + ADDR_W'(c);
  endfunction

  function automatic logic [7:0] clamp8(input logic [9:0] v);
    return (v > 10'd255) ? 8'hFF : v[7:0];
  endfunction

  function automatic rgb_t palette(input logic mode, input logic [7:0] h);
    logic [9:0] x;
    logic [9:0] hw;
    rgb_t       o;
    hw = {2'b00, h};
    x  = (hw << 1) + hw;
    if (mode) begin
      o.r = clamp8(x);
      o.g = (x > 10'd255) ? clamp8(x - 10'd255) : 8'd0;
      o.b = (x > 10'd510) ? clamp8(x - 10'd510) : 8'd0;
    end else begin
      o.r = h;
      o.g = (h > 8'd128) ? clamp8((hw - 10'd128) << 1) : 8'd0;
      o.b = (h > 8'd224) ? clamp8((hw - 10'd224) << 2) : 8'd0;
    end
    return o;
  endfunction

endpackage

// ===== sv/fhd_ram.sv =====
// ----------------------------------------------------------------------------
// fhd_ram: generic RAM
// One write port, two read ports, read data registered.
// ----------------------------------------------------------------------------
module fhd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== sv/fire_heat_diffusion_top.sv =====
// ----------------------------------------------------------------------------
// fire_heat_diffusion_top: fire effect heat grid with palette read-out
//
// Input channel (in_valid/in_ready, fields cmd/row/col) takes one transaction
// per item. cmd = tick runs one simulation step and returns nothing; cmd =
// read returns one transaction on the output channel (out_valid/out_ready)
// with the cell's colour and raw heat, all zero for a cell outside the grid.
// Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_data);
// writing rng_seed reloads the generator, zero meaning the default seed.
// Write it only while the block is idle.
// Read: accept presents the address to the RAM, and S_PIX loads the read
// data into the output register. Tick: seeding visits each bottom cell in
// S_SEED, adding S_DRAW2 (second draw) and an 8-step bit-serial remainder
// in S_MOD when a spark spawns; then each upper cell runs S_RD1, S_RD2,
// S_CALC, S_WR; the single shared subtractor and two read ports set this order.
// Reset clears the grid at once through per-row valid bits (no clearing
// pass), loads the default seed and register values.
// A stalled receiver holds a read in its last cycle; ticks still proceed
// while a result waits in the output register.
// ----------------------------------------------------------------------------
module fire_heat_diffusion_top
  import fhd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 cmd,
  input  logic [3:0]           row,
  input  logic [3:0]           col,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           red,
  output logic [7:0]           green,
  output logic [7:0]           blue,
  output logic [7:0]           heat_value,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_PIX   = 9'b000000010,
    S_SEED  = 9'b000000100,
    S_DRAW2 = 9'b000001000,
    S_MOD   = 9'b000010000,
    S_RD1   = 9'b000100000,
    S_RD2   = 9'b001000000,
    S_CALC  = 9'b010000000,
    S_WR    = 9'b100000000
  } state_t;

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GRID_ROWS - 1);
  localparam logic [ROW_W-1:0] PROP_END = ROW_W'(GRID_ROWS - 2);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(GRID_COLS - 1);

  state_t state;

  // configuration
  logic       palette_mode;
  logic [7:0] spawn_threshold;
  logic [7:0] spark_min;
  logic [7:0] cooling;
  logic [31:0] rng;

  // sequencer position
  logic [ROW_W-1:0] r;
  logic [COL_W-1:0] c;
  logic [ROW_W-1:0] pix_row;
  logic [COL_W-1:0] pix_col;
  logic             pix_oob;

  // remainder unit
  logic [7:0] num;
  logic [7:0] rem;
  logic [2:0] mod_cnt;

  // cell update datapath
  logic [7:0]  below;
  logic [7:0]  below2;
  logic [23:0] prod;

  // grid storage
  logic [GRID_ROWS-1:0] row_valid;
  logic                 va_q;
  logic                 vb_q;
  logic [7:0]           rdata_a;
  logic [7:0]           rdata_b;
  logic [7:0]           da;
  logic [7:0]           db;
  logic [ROW_W-1:0]     a_row;
  logic [COL_W-1:0]     a_col;
  logic [ROW_W-1:0]     b_row;
  logic [COL_W-1:0]     b_col;
  logic                 mem_we;
  logic [ROW_W-1:0]     w_row;
  logic [7:0]           w_data;

  // shared subtractor
  logic [8:0] sub_a;
  logic [8:0] sub_b;
  logic [9:0] diff;
  logic       borrow;

  logic [31:0]    xs_next;
  logic [8:0]     span;
  logic [8:0]     rem_shift;
  logic [7:0]     rem_next;
  logic [ROW_W:0] r_plus2;
  logic [ROW_W-1:0] r2_row;
  logic [10:0]    sum;
  logic [7:0]     avg;
  logic [7:0]     cooled;
  logic           out_free;
  logic           in_oob;
  logic [7:0]     pix_heat;
  rgb_t           pix_rgb;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  assign xs_next   = xs32(rng);
  assign span      = 9'd256 - {1'b0, spark_min};
  assign rem_shift = {rem, num[7]};
  assign r_plus2   = {1'b0, r} + (ROW_W + 1)'(2);
  assign r2_row    = (r_plus2 < (ROW_W + 1)'(GRID_ROWS)) ? r_plus2[ROW_W-1:0] : r + 1'b1;
  assign in_oob    = (int'(row) >= GRID_ROWS) || (int'(col) >= GRID_COLS);

  assign da = va_q ? rdata_a : 8'd0;
  assign db = vb_q ? rdata_b : 8'd0;

  // one subtractor: spawn compare, remainder step, cooling
  always_comb begin
    case (state)
      S_SEED: begin
        sub_a = {1'b0, xs_next[31:24]};
        sub_b = {1'b0, spawn_threshold};
      end
      S_MOD: begin
        sub_a = rem_shift;
        sub_b = span;
      end
      default: begin
        sub_a = {1'b0, avg};
        sub_b = {1'b0, cooling};
      end
    endcase
  end

  assign diff     = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow   = diff[9];
  assign rem_next = borrow ? rem_shift[7:0] : diff[7:0];
  assign avg      = prod[23:16];
  assign cooled   = borrow ? 8'd0 : diff[7:0];
  assign sum      = {2'b00, below, 1'b0} + {3'b000, da} + {3'b000, db} + {3'b000, below2};

  // read addresses
  always_comb begin
    b_row = r + 1'b1;
    b_col = c;
    case (state)
      S_IDLE: begin
        a_row = ROW_W'(row);
        a_col = COL_W'(col);
      end
      S_PIX: begin
        a_row = pix_row;
        a_col = pix_col;
      end
      S_RD1: begin
        a_row = r + 1'b1;
        a_col = c;
        b_row = r2_row;
      end
      S_RD2: begin
        a_row = r + 1'b1;
        a_col = (c == '0) ? c : c - 1'b1;
        b_col = (c == LAST_COL) ? c : c + 1'b1;
      end
      default: begin
        a_row = r + 1'b1;
        a_col = c;
      end
    endcase
  end

  // write port
  always_comb begin
    mem_we = 1'b0;
    w_row  = r;
    w_data = cooled;
    case (state)
      S_SEED: begin
        mem_we = borrow == 1'b0;
        w_row  = LAST_ROW;
        w_data = 8'd0;
      end
      S_MOD: begin
        mem_we = (mod_cnt == 3'd7);
        w_row  = LAST_ROW;
        w_data = spark_min + rem_next;
      end
      S_WR: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  fhd_ram #(
    .WIDTH (8),
    .DEPTH (CELLS)
  ) u_grid (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (cell_addr(w_row, c)),
    .wdata   (w_data),
    .raddr_a (cell_addr(a_row, a_col)),
    .rdata_a (rdata_a),
    .raddr_b (cell_addr(b_row, b_col)),
    .rdata_b (rdata_b)
  );

  assign pix_heat = pix_oob ? 8'd0 : da;
  assign pix_rgb  = palette(palette_mode, pix_heat);

  // payload registers
  always_ff @(posedge clk) begin
    va_q <= row_valid[a_row];
    vb_q <= row_valid[b_row];
    if (state == S_IDLE) begin
      pix_row <= ROW_W'(row);
      pix_col <= COL_W'(col);
      pix_oob <= in_oob;
    end
    if (state == S_DRAW2) begin
      num <= xs_next[31:24];
      rem <= 8'd0;
    end
    if (state == S_MOD) begin
      num <= num << 1;
      rem <= rem_next;
    end
    if (state == S_RD2) begin
      below  <= da;
      below2 <= db;
    end
    if (state == S_CALC) begin
      prod <= 24'(sum) * 24'(RECIP6);
    end
    if (state == S_PIX && out_free) begin
      red        <= pix_rgb.r;
      green      <= pix_rgb.g;
      blue       <= pix_rgb.b;
      heat_value <= pix_heat;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      row_valid       <= '0;
      r               <= '0;
      c               <= '0;
      mod_cnt         <= '0;
      rng             <= SEED_DEFAULT;
      palette_mode    <= 1'b0;
      spawn_threshold <= THR_RESET;
      spark_min       <= SPARK_RESET;
      cooling         <= COOL_RESET;
    end else begin
      if (mem_we) begin
        row_valid[w_row] <= 1'b1;
      end

      if (state == S_PIX && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (cmd == CMD_READ) begin
              state <= S_PIX;
            end else begin
              c     <= '0;
              state <= S_SEED;
            end
          end
        end
        S_PIX: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_SEED: begin
          rng <= xs_next;
          if (borrow) begin
            state <= S_DRAW2;
          end else if (c == LAST_COL) begin
            c     <= '0;
            r     <= '0;
            state <= S_RD1;
          end else begin
            c <= c + 1'b1;
          end
        end
        S_DRAW2: begin
          rng     <= xs_next;
          mod_cnt <= '0;
          state   <= S_MOD;
        end
        S_MOD: begin
          mod_cnt <= mod_cnt + 1'b1;
          if (mod_cnt == 3'd7) begin
            if (c == LAST_COL) begin
              c     <= '0;
              r     <= '0;
              state <= S_RD1;
            end else begin
              c     <= c + 1'b1;
              state <= S_SEED;
            end
          end
        end
        S_RD1: begin
          state <= S_RD2;
        end
        S_RD2: begin
          state <= S_CALC;
        end
        S_CALC: begin
          state <= S_WR;
        end
        S_WR: begin
          state <= S_RD1;
          if (c == LAST_COL) begin
            c <= '0;
            if (r == PROP_END) begin
              state <= S_IDLE;
            end else begin
              r <= r + 1'b1;
            end
          end else begin
            c <= c + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (cfg_wr_en) begin
        case (cfg_index)
          REG_PALETTE_MODE:    palette_mode    <= cfg_data[0];
          REG_SPAWN_THRESHOLD: spawn_threshold <= cfg_data[7:0];
          REG_SPARK_MIN:       spark_min       <= cfg_data[7:0];
          REG_COOLING:         cooling         <= cfg_data[7:0];
          REG_RNG_SEED:        rng <= (cfg_data == 32'd0) ? SEED_DEFAULT : cfg_data;
          default:             ;
        endcase
      end
    end
  end

  // checks
  a_rem_below_span: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOD) |-> ({1'b0, rem} < span))
    else $error("remainder out of range");

  a_write_only_in_tick: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_SEED || state == S_MOD || state == S_WR))
    else $error("grid write outside a tick");

  a_read_goes_pix: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && cmd == CMD_READ) |=> (state == S_PIX))
    else $error("read transaction not serviced");

  a_pix_loads_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_PIX && out_free) |=> (out_valid && state == S_IDLE))
    else $error("read result not presented");

  a_rng_nonzero: assert property (@(posedge clk) disable iff (rst)
    rng != 32'd0)
    else $error("generator stuck at zero");

endmodule
